>>> rtl/mqts_pkg.sv
`timescale 1ns / 1ps

package mqts_pkg;

    localparam int DATA_W = 32;

    // opcodes; the unused code behaves as a query
    localparam logic [1:0] OP_ENQ   = 2'd0;
    localparam logic [1:0] OP_DEQ   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // reported maximum of an empty queue
    localparam logic signed [DATA_W-1:0] EMPTY_MAX = -32'sd2100000000;

    // one store entry: value plus prefix max of its own stack
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] pmax;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;       // input transfer this cycle
        logic xfer_rd;      // read front top, pop front
        logic xfer_wr;      // push read value onto back
        logic pop_rd;       // read back top and the entry below it
        logic pop_fin;      // capture dequeued value, new back max
        logic load_result;  // fill output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_deq;       // opcode on the input port is a dequeue
        logic front_empty;
        logic back_empty;
    } dp_status_t;

endpackage

>>> rtl/mqts_controller.sv
`timescale 1ns / 1ps

module mqts_controller
    import mqts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_XFER_RD = 6'b000010,
        ST_XFER_WR = 6'b000100,
        ST_POP_RD  = 6'b001000,
        ST_POP_FIN = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   slot_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (status.is_deq && !status.back_empty)
                        state_next = ST_POP_RD;
                    else if (status.is_deq && !status.front_empty)
                        state_next = ST_XFER_RD;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_XFER_RD:
            begin
                cmd.xfer_rd = 1'b1;
                state_next  = ST_XFER_WR;
            end
            ST_XFER_WR:
            begin
                cmd.xfer_wr = 1'b1;
                state_next  = status.front_empty ? ST_POP_RD : ST_XFER_RD;
            end
            ST_POP_RD:
            begin
                cmd.pop_rd = 1'b1;
                state_next = ST_POP_FIN;
            end
            ST_POP_FIN:
            begin
                cmd.pop_fin = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // never overwrite a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while stalled");

    // an accepted item always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted item not processed");

    // a transfer only starts on a dequeue with an empty back stack
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && (state_next == ST_XFER_RD)
            |-> status.back_empty && !status.front_empty)
        else $error("front stack moved while back stack holds entries");

endmodule

>>> rtl/mqts_datapath.sv
`timescale 1ns / 1ps

module mqts_datapath
    import mqts_pkg::*;
#(
    parameter int CAPACITY = 1024,
    localparam int ADDR_W = $clog2(CAPACITY),
    localparam int CNT_W  = $clog2(CAPACITY + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic [1:0]               opcode,
    input  logic signed [DATA_W-1:0] enq_value,
    output logic signed [DATA_W-1:0] deq_value,
    output logic                     deq_valid,
    output logic signed [DATA_W-1:0] max_value,
    output logic                     is_empty,
    output logic                     overflow,
    output logic                     underflow
);

    localparam logic [CNT_W-1:0]  CAP_C  = CNT_W'(CAPACITY);
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(CAPACITY - 1);

    // storage
    entry_t mem [CAPACITY];
    entry_t rd_a_reg;
    entry_t rd_b_reg;

    logic [CNT_W-1:0]          front_count_reg;
    logic [CNT_W-1:0]          front_count_next;
    logic [CNT_W-1:0]          back_count_reg;
    logic [CNT_W-1:0]          back_count_next;
    logic signed [DATA_W-1:0]  front_max_reg;
    logic signed [DATA_W-1:0]  back_max_reg;

    logic signed [DATA_W-1:0]  deq_hold_reg;
    logic                      deq_ok_reg;
    logic                      ovf_reg;
    logic                      unf_reg;

    logic signed [DATA_W-1:0]  deq_value_reg;
    logic                      deq_valid_reg;
    logic signed [DATA_W-1:0]  max_value_reg;
    logic                      is_empty_reg;
    logic                      overflow_reg;
    logic                      underflow_reg;

    logic                      front_empty;
    logic                      back_empty;
    logic [CNT_W:0]            fill_sum;
    logic                      full;
    logic                      enq_go;
    logic [CNT_W-1:0]          front_top;
    logic [CNT_W-1:0]          back_top;
    logic [CNT_W-1:0]          back_push;
    logic [ADDR_W-1:0]         back_top_a;
    logic signed [DATA_W-1:0]  enq_pmax;
    logic signed [DATA_W-1:0]  xfer_pmax;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    entry_t                    wr_data;
    logic [ADDR_W-1:0]         rd_a_addr;
    logic [ADDR_W-1:0]         rd_b_addr;
    logic signed [DATA_W-1:0]  max_now;

    assign front_empty = (front_count_reg == '0);
    assign back_empty  = (back_count_reg == '0);
    assign fill_sum    = {1'b0, front_count_reg} + {1'b0, back_count_reg};
    assign full        = (fill_sum >= (CNT_W + 1)'(CAPACITY));

    assign status.is_deq      = (opcode == OP_DEQ);
    assign status.front_empty = front_empty;
    assign status.back_empty  = back_empty;

    assign enq_go    = cmd.accept && (opcode == OP_ENQ) && !full;
    assign front_top = front_count_reg - 1'b1;
    assign back_top  = CAP_C - back_count_reg;
    assign back_push = CAP_C - back_count_reg - 1'b1;
    assign back_top_a = back_top[ADDR_W-1:0];

    assign enq_pmax  = (front_empty || (enq_value > front_max_reg)) ? enq_value
                                                                    : front_max_reg;
    assign xfer_pmax = (back_empty || (rd_a_reg.value > back_max_reg)) ? rd_a_reg.value
                                                                       : back_max_reg;

    // one write port, shared by enqueue and transfer
    always_comb
    begin
        wr_en = enq_go || cmd.xfer_wr;
        if (enq_go)
        begin
            wr_addr       = front_count_reg[ADDR_W-1:0];
            wr_data.value = enq_value;
            wr_data.pmax  = enq_pmax;
        end
        else
        begin
            wr_addr       = back_push[ADDR_W-1:0];
            wr_data.value = rd_a_reg.value;
            wr_data.pmax  = xfer_pmax;
        end
    end

    // port A: front top during transfer, back top on pop; port B: entry below back top
    assign rd_a_addr = cmd.pop_rd ? back_top_a : front_top[ADDR_W-1:0];
    assign rd_b_addr = (back_top_a == LAST_A) ? '0 : back_top_a + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_comb
    begin
        front_count_next = front_count_reg;
        back_count_next  = back_count_reg;
        if (enq_go)
            front_count_next = front_count_reg + 1'b1;
        else if (cmd.xfer_rd)
            front_count_next = front_count_reg - 1'b1;
        if (cmd.xfer_wr)
            back_count_next = back_count_reg + 1'b1;
        else if (cmd.pop_rd)
            back_count_next = back_count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_count_reg <= '0;
            back_count_reg  <= '0;
        end
        else
        begin
            front_count_reg <= front_count_next;
            back_count_reg  <= back_count_next;
        end
    end

    // top-of-stack maxima and per-item flags
    always_ff @(posedge clk)
    begin
        if (enq_go)
            front_max_reg <= enq_pmax;
        if (cmd.xfer_wr)
            back_max_reg <= xfer_pmax;
        else if (cmd.pop_fin && !back_empty)
            back_max_reg <= rd_b_reg.pmax;

        if (cmd.accept)
        begin
            deq_ok_reg   <= 1'b0;
            deq_hold_reg <= '0;
            ovf_reg      <= (opcode == OP_ENQ) && full;
            unf_reg      <= (opcode == OP_DEQ) && front_empty && back_empty;
        end
        else if (cmd.pop_fin)
        begin
            deq_ok_reg   <= 1'b1;
            deq_hold_reg <= rd_a_reg.value;
        end
    end

    always_comb
    begin
        priority if (front_empty && back_empty)
            max_now = EMPTY_MAX;
        else if (front_empty)
            max_now = back_max_reg;
        else if (back_empty)
            max_now = front_max_reg;
        else
            max_now = (front_max_reg > back_max_reg) ? front_max_reg : back_max_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            deq_value_reg <= deq_hold_reg;
            deq_valid_reg <= deq_ok_reg;
            max_value_reg <= max_now;
            is_empty_reg  <= front_empty && back_empty;
            overflow_reg  <= ovf_reg;
            underflow_reg <= unf_reg;
        end
    end

    assign deq_value = deq_value_reg;
    assign deq_valid = deq_valid_reg;
    assign max_value = max_value_reg;
    assign is_empty  = is_empty_reg;
    assign overflow  = overflow_reg;
    assign underflow = underflow_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_sum <= (CNT_W + 1)'(CAPACITY))
        else $error("stacks hold more than the store");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_rd |-> !back_empty)
        else $error("pop from empty back stack");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.xfer_rd |-> !front_empty)
        else $error("transfer read from empty front stack");

endmodule

>>> rtl/max_queue_two_stacks_top.sv
`timescale 1ns / 1ps

// Channel  Handshake           Payload
// in       in_valid/in_stall   opcode, enq_value
// out      out_valid/out_stall deq_value, deq_valid, max_value, is_empty, overflow, underflow
//
// Enqueue, query and empty dequeue: accept, then output register load.
// Dequeue with entries in the back stack: accept, dual-port read, capture, load.
// Dequeue with an empty back stack: the front stack moves over first; the store's
// single write port moves one entry per read/write pair, and then the pop runs as above.
// rst_n clears both stack counts and the output valid; the store needs no clearing.
// A result waiting under out_stall does not block the next input transfer; the block
// only holds in its final step until the output register is free.

module max_queue_two_stacks_top
    import mqts_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               opcode,
    input  logic signed [DATA_W-1:0] enq_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] deq_value,
    output logic                     deq_valid,
    output logic signed [DATA_W-1:0] max_value,
    output logic                     is_empty,
    output logic                     overflow,
    output logic                     underflow
);

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    mqts_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // store, stack counts, top maxima, output register
    mqts_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .opcode    (opcode),
        .enq_value (enq_value),
        .deq_value (deq_value),
        .deq_valid (deq_valid),
        .max_value (max_value),
        .is_empty  (is_empty),
        .overflow  (overflow),
        .underflow (underflow)
    );

endmodule

>>> tb/max_queue_check_pkg.sv
`timescale 1ns / 1ps

package max_queue_check_pkg;

    import mqts_pkg::*;

    localparam int STORE_DEPTH = 1024;

    typedef struct packed {
        logic signed [DATA_W-1:0] deq_value;
        logic                     deq_valid;
        logic signed [DATA_W-1:0] max_value;
        logic                     is_empty;
        logic                     overflow;
        logic                     underflow;
    } queue_result_t;

    // Two-stack queue with per-entry prefix max, plus the results still owed.
    class max_queue_scoreboard;

        logic signed [DATA_W-1:0] value_mem [STORE_DEPTH];
        logic signed [DATA_W-1:0] pmax_mem  [STORE_DEPTH];
        int unsigned              front_n;
        int unsigned              back_n;
        queue_result_t            expected_results [$];
        int unsigned              errors;

        function new();
            front_n = 0;
            back_n  = 0;
            errors  = 0;
        endfunction

        function int unsigned occupancy();
            return front_n + back_n;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void note_transfer(logic [1:0] op, logic signed [DATA_W-1:0] val);
            queue_result_t            r;
            logic signed [DATA_W-1:0] moved;
            logic signed [DATA_W-1:0] best;
            int unsigned              slot;
            r = '0;
            if (op == OP_ENQ)
            begin
                if (front_n + back_n >= STORE_DEPTH)
                    r.overflow = 1'b1;
                else
                begin
                    value_mem[front_n] = val;
                    if (front_n == 0 || val > pmax_mem[front_n - 1])
                        pmax_mem[front_n] = val;
                    else
                        pmax_mem[front_n] = pmax_mem[front_n - 1];
                    front_n++;
                end
            end
            else if (op == OP_DEQ)
            begin
                if (back_n == 0)
                begin
                    // reverse the whole front stack onto the back stack
                    while (front_n != 0)
                    begin
                        front_n--;
                        moved = value_mem[front_n];
                        slot  = STORE_DEPTH - 1 - back_n;
                        value_mem[slot] = moved;
                        if (back_n == 0 || moved > pmax_mem[slot + 1])
                            pmax_mem[slot] = moved;
                        else
                            pmax_mem[slot] = pmax_mem[slot + 1];
                        back_n++;
                    end
                end
                if (back_n == 0)
                    r.underflow = 1'b1;
                else
                begin
                    back_n--;
                    r.deq_value = value_mem[STORE_DEPTH - 1 - back_n];
                    r.deq_valid = 1'b1;
                end
            end
            // max over the non-empty stacks only
            best = EMPTY_MAX;
            if (front_n != 0)
                best = pmax_mem[front_n - 1];
            if (back_n != 0 && (front_n == 0 || pmax_mem[STORE_DEPTH - back_n] > best))
                best = pmax_mem[STORE_DEPTH - back_n];
            r.max_value = best;
            r.is_empty  = (front_n == 0 && back_n == 0);
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [DATA_W-1:0] want,
                                    logic signed [DATA_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(queue_result_t got);
            queue_result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with no transfer waiting: deq_value %0d max_value %0d",
                       $signed(got.deq_value), $signed(got.max_value));
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("deq_value", want.deq_value, got.deq_value);
            compare_field("deq_valid", want.deq_valid, got.deq_valid);
            compare_field("max_value", want.max_value, got.max_value);
            compare_field("is_empty",  want.is_empty,  got.is_empty);
            compare_field("overflow",  want.overflow,  got.overflow);
            compare_field("underflow", want.underflow, got.underflow);
        endfunction

    endclass

endpackage

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import mqts_pkg::*;
    import max_queue_check_pkg::*;

    // the fourth opcode has no meaning of its own and must act as a query
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;

    // generous: every item paying a long sender gap, a long receiver stall
    // and the block's own cycles, several times over
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 50;

    typedef enum {MIX_TRAFFIC, FILL_STORE, DRAIN_STORE} traffic_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [1:0]               opcode    = OP_QUERY;
    logic signed [DATA_W-1:0] enq_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] deq_value;
    logic                     deq_valid;
    logic signed [DATA_W-1:0] max_value;
    logic                     is_empty;
    logic                     overflow;
    logic                     underflow;

    max_queue_scoreboard queue_model;
    queue_result_t       seen_result;
    int unsigned         items_sent  = 0;
    int unsigned         cycle_count = 0;
    bit                  idle_mode   = 1'b1;   // 0: both sides run flat out
    int                  stall_left  = 0;

    max_queue_two_stacks_top #(
        .CAPACITY (STORE_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .enq_value (enq_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .deq_value (deq_value),
        .deq_valid (deq_valid),
        .max_value (max_value),
        .is_empty  (is_empty),
        .overflow  (overflow),
        .underflow (underflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        if (!idle_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Values lean on the extremes, the area around the empty-queue sentinel
    // (including values below it) and a narrow band that produces ties.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return EMPTY_MAX + $signed($urandom_range(0, 4)) - 2;
            3, 4:    return $signed($urandom_range(0, 15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stall bursts, changed only at the falling edge.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (idle_mode && $urandom_range(0, 99) < 35)
        begin
            out_stall <= 1'b1;
            stall_left = idle_len();
        end
        else
            out_stall <= 1'b0;
    end

    // Result monitor: a transfer happens on a rising edge with valid up and
    // stall down; both are read before the edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_result.deq_value = deq_value;
            seen_result.deq_valid = deq_valid;
            seen_result.max_value = max_value;
            seen_result.is_empty  = is_empty;
            seen_result.overflow  = overflow;
            seen_result.underflow = underflow;
            queue_model.check_result(seen_result);
        end
    end

    // One input transfer. Payload goes out at the falling edge and stays put
    // until accepted. With no gap, valid simply stays high for the next item,
    // so it is never lowered and raised in the same step.
    task automatic send_item(input logic [1:0] op, input logic signed [DATA_W-1:0] val);
        int gap;
        @(negedge clk);
        in_valid  <= 1'b1;
        opcode    <= op;
        enq_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        queue_model.note_transfer(op, val);
        items_sent++;
        // every so often switch between idling and full-rate stretches
        if (items_sent % 64 == 0)
            idle_mode = ($urandom_range(0, 3) != 0);
        gap = idle_len();
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // Opcode mix depends on what the current stretch is after: a balanced
    // mix, filling the store past capacity, or draining it.
    task automatic random_item(input traffic_t mode, output logic [1:0] op);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            FILL_STORE:
                op = (r < 95) ? OP_ENQ : (r < 98) ? OP_DEQ : OP_QUERY;
            DRAIN_STORE:
                op = (r < 92) ? OP_DEQ : (r < 96) ? OP_ENQ : (r < 98) ? OP_QUERY : OP_SPARE;
            default:
                op = (r < 48) ? OP_ENQ : (r < 88) ? OP_DEQ : (r < 96) ? OP_QUERY : OP_SPARE;
        endcase
        send_item(op, pick_value());
    endtask

    initial
    begin
        logic [1:0]  op;
        int unsigned occ;
        int          dropped;

        queue_model = new();
        dropped     = 0;

        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // empty queue: query, dequeue with stray data, spare opcode
        send_item(OP_QUERY, '0);
        send_item(OP_DEQ, 32'sd5);
        send_item(OP_SPARE, MOST_POS);
        // maxima below the sentinel must be reported as they are
        send_item(OP_ENQ, MOST_NEG);
        send_item(OP_ENQ, EMPTY_MAX - 1);
        send_item(OP_QUERY, -32'sd1);
        // first dequeue walks the front stack over
        send_item(OP_DEQ, '0);
        // max now comes from the front stack, back stack holds the low one
        send_item(OP_ENQ, MOST_POS);
        send_item(OP_DEQ, MOST_POS);
        send_item(OP_DEQ, '0);
        send_item(OP_DEQ, '0);
        // the sentinel value itself in a non-empty queue
        send_item(OP_ENQ, EMPTY_MAX);
        send_item(OP_ENQ, '0);
        send_item(OP_ENQ, -32'sd1);
        send_item(OP_SPARE, 32'sd77);
        send_item(OP_DEQ, '0);
        // ties and alternating bit patterns, then dequeue through empty
        send_item(OP_ENQ, 32'sd1);
        send_item(OP_ENQ, 32'sd1);
        send_item(OP_ENQ, 32'sh5555_5555);
        send_item(OP_ENQ, 32'shAAAA_AAAA);
        repeat (7)
            send_item(OP_DEQ, MOST_NEG);

        // ---- random part ----
        repeat (80)
            random_item(MIX_TRAFFIC, op);

        // fill to capacity and keep pushing into the full store a few times
        while (dropped < 6)
        begin
            occ = queue_model.occupancy();
            random_item(FILL_STORE, op);
            if (occ == STORE_DEPTH && op == OP_ENQ)
                dropped++;
        end

        // mostly dequeues from a full store; once the back stack runs dry
        // the next dequeue moves the whole front stack over
        repeat (60)
            random_item(DRAIN_STORE, op);

        @(negedge clk);
        in_valid <= 1'b0;

        // wait for every owed result, then a short settle for strays
        while (queue_model.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (queue_model.errors == 0 && queue_model.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
